### src/msps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_pkg: shared types and constants
// Field widths, register codes and the configuration bundle of the scan unit.
// ----------------------------------------------------------------------------
package msps_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned OffsetOutW = 32;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned SigBytes  = 16;
  localparam int unsigned LenRegW   = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBytesLow  = 3'd0,
    CfgBytesHigh = 3'd1,
    CfgMasksLow  = 3'd2,
    CfgMasksHigh = 3'd3,
    CfgLength    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SigBytes*ByteW-1:0] sig_bytes;
    logic [SigBytes*ByteW-1:0] sig_masks;
    logic [LenRegW-1:0]        len;       // already clamped to 1..PATTERN_MAX
  } cfg_t;

endpackage

### src/msps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_if: stream channels of the scan unit
// Request channel (buffer bytes) and result channel (match reports).
// ----------------------------------------------------------------------------
interface msps_req_if;
  logic                      valid;
  logic                      ready;
  logic [msps_pkg::ByteW-1:0] data_byte;
  logic                      last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface msps_res_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [msps_pkg::OffsetOutW-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

### src/msps_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_cfg_regs: configuration registers
// Signature bytes, masks and length; length is clamped on the way out.
// ----------------------------------------------------------------------------
module msps_cfg_regs #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [msps_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [msps_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output msps_pkg::cfg_t                    cfg_o
);

  logic [msps_pkg::CfgDataW-1:0] bytes_lo_q, bytes_hi_q, masks_lo_q, masks_hi_q;
  logic [msps_pkg::LenRegW-1:0]  len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_lo_q <= '0;
      bytes_hi_q <= '0;
      masks_lo_q <= '0;
      masks_hi_q <= '0;
      len_q      <= msps_pkg::LenRegW'(1);
    end else if (cfg_we_i) begin
      case (msps_pkg::cfg_idx_e'(cfg_idx_i))
        msps_pkg::CfgBytesLow:  bytes_lo_q <= cfg_wdata_i;
        msps_pkg::CfgBytesHigh: bytes_hi_q <= cfg_wdata_i;
        msps_pkg::CfgMasksLow:  masks_lo_q <= cfg_wdata_i;
        msps_pkg::CfgMasksHigh: masks_hi_q <= cfg_wdata_i;
        msps_pkg::CfgLength:    len_q      <= cfg_wdata_i[msps_pkg::LenRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.sig_bytes = {bytes_hi_q, bytes_lo_q};
    cfg_o.sig_masks = {masks_hi_q, masks_lo_q};
    if (len_q == '0) begin
      cfg_o.len = msps_pkg::LenRegW'(1);
    end else if (len_q > msps_pkg::LenRegW'(PATTERN_MAX)) begin
      cfg_o.len = msps_pkg::LenRegW'(PATTERN_MAX);
    end else begin
      cfg_o.len = len_q;
    end
  end

endmodule

### src/msps_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_match: masked window compare
// Aligns the signature to the newest len bytes and checks every lane at once.
// ----------------------------------------------------------------------------
module msps_match #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic [msps_pkg::ByteW-1:0] win_i [PATTERN_MAX],
  input  msps_pkg::cfg_t             cfg_i,
  output logic                       match_o
);

  logic [msps_pkg::ByteW-1:0] got      [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]     lane_ok;

  // Signature byte i lines up with window entry len-1-i (entry 0 is newest).
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      got[i] = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (j + i + 1 == int'(cfg_i.len)) begin
          got[i] = win_i[j];
        end
      end
      lane_ok[i] = (i >= int'(cfg_i.len)) ||
                   (((got[i] ^ cfg_i.sig_bytes[i*msps_pkg::ByteW +: msps_pkg::ByteW]) &
                     cfg_i.sig_masks[i*msps_pkg::ByteW +: msps_pkg::ByteW]) == '0);
    end
    match_o = &lane_ok;
  end

endmodule

### src/masked_byte_pattern_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_unit: wildcard masked byte signature search
// Scans a byte stream for the first match of a masked signature of up to
// PATTERN_MAX bytes and reports its start offset, or not found at buffer end.
// ----------------------------------------------------------------------------
//  channel | dir | payload                      | request taken when
//  --------+-----+------------------------------+-------------------------
//  req_i   | in  | data_byte[7:0], last_byte    | valid & ready
//  res_o   | out | found, match_offset[31:0]    | valid & ready
//  cfg     | in  | cfg_idx_i, cfg_wdata_i[63:0] | cfg_we_i
//
//  One byte per clock, sustained while results are taken. A byte is captured
//  in the input register; when it advances, the window shifts, the counter
//  bumps and the result register loads.
//  Reset (async, active low) empties both stages, clears window, counter and
//  found flag, and restores the registers (length 1).
//  A stalled result holds the input stage; req_i.ready then drops, so at most
//  one byte waits behind a result that is not taken.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_unit #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [msps_pkg::CfgDataW-1:0] cfg_wdata_i,
  msps_req_if.sink                      req_i,
  msps_res_if.source                    res_o
);

  localparam int unsigned ExtW = (OFFSET_BITS > msps_pkg::OffsetOutW) ?
                                 OFFSET_BITS : msps_pkg::OffsetOutW;
  localparam logic [OFFSET_BITS-1:0] CountMax = '1;

  msps_pkg::cfg_t cfg;

  msps_cfg_regs #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register
  logic                       in_valid_q;
  logic [msps_pkg::ByteW-1:0] in_data_q;
  logic                       in_last_q;

  // Buffer state
  logic [msps_pkg::ByteW-1:0] win_q     [PATTERN_MAX];
  logic [msps_pkg::ByteW-1:0] win_shift [PATTERN_MAX];
  logic [OFFSET_BITS-1:0]     count_q, count_nxt;
  logic                       done_q;

  // Result register
  logic                            out_valid_q, out_valid_d;
  logic                            out_found_q;
  logic [msps_pkg::OffsetOutW-1:0] out_offset_q;

  logic                   advance;
  logic                   window_hit;
  logic                   hit;
  logic                   emit;
  logic [OFFSET_BITS-1:0] len_ext;
  logic [OFFSET_BITS-1:0] offset_raw;
  logic [ExtW-1:0]        offset_ext;

  // The input stage moves on when the result register is free or drains now.
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_data_q <= req_i.data_byte;
      in_last_q <= req_i.last_byte;
    end
  end

  // Window as it stands once the held byte is shifted in.
  always_comb begin
    win_shift[0] = in_data_q;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_shift[k] = win_q[k-1];
    end
  end

  assign count_nxt = (count_q == CountMax) ? count_q : count_q + OFFSET_BITS'(1);
  assign len_ext   = OFFSET_BITS'(cfg.len);

  msps_match #(.PATTERN_MAX(PATTERN_MAX)) u_match (
    .win_i   (win_shift),
    .cfg_i   (cfg),
    .match_o (window_hit)
  );

  // First match only; a buffer without one reports not found on its last byte.
  assign hit        = !done_q && (count_nxt >= len_ext) && window_hit;
  assign emit       = hit || (in_last_q && !done_q);
  assign offset_raw = count_nxt - len_ext;
  assign offset_ext = ExtW'(offset_raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_q[k] <= '0;
      end
      count_q <= '0;
      done_q  <= 1'b0;
    end else if (advance) begin
      if (in_last_q) begin
        // buffer end: start the next buffer from scratch
        for (int k = 0; k < PATTERN_MAX; k++) begin
          win_q[k] <= '0;
        end
        count_q <= '0;
        done_q  <= 1'b0;
      end else begin
        win_q   <= win_shift;
        count_q <= count_nxt;
        done_q  <= done_q || hit;
      end
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_d = emit;
    end else begin
      out_valid_d = out_valid_q && !res_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_found_q  <= hit;
      out_offset_q <= hit ? offset_ext[msps_pkg::OffsetOutW-1:0] : '0;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.found        = out_found_q;
  assign res_o.match_offset = out_offset_q;

endmodule

### src/msps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_checker: port-level checks for the scan unit
// Watches the request and result channels from outside.
// ----------------------------------------------------------------------------
module msps_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic                            res_valid_i,
  input logic                            res_ready_i,
  input logic                            res_found_i,
  input logic [msps_pkg::OffsetOutW-1:0] res_offset_i
);

  // A stalled result stays up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // Not-found reports carry a zero offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_found_i |-> res_offset_i == '0)
    else $error("not-found result with nonzero offset");

  // Request side only backs up behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> res_valid_i && !res_ready_i)
    else $error("request stalled without result backpressure");

  // A fresh result follows a taken request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(req_valid_i && req_ready_i, 2))
    else $error("result without a matching request");

endmodule

bind masked_byte_pattern_scan_unit msps_checker u_msps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_found_i  (res_o.found),
  .res_offset_i (res_o.match_offset)
);

### bench/msps_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_scan_checker: scoreboard for the masked byte signature scan
// Tracks register writes, predicts the match reports due for accepted buffer
// bytes and checks each taken result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module msps_scan_checker #(
  parameter int unsigned PatternMax = 16,
  parameter int unsigned OffsetBits = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [msps_pkg::CfgDataW-1:0] cfg_wdata_i,
  msps_req_if                           req_mon,
  msps_res_if                           res_mon,
  output int unsigned                   pending_o,
  output int unsigned                   fail_count_o
);
  import msps_pkg::*;

  typedef struct packed {
    logic                  found;
    logic [OffsetOutW-1:0] match_offset;
  } scan_res_t;

  // register copy
  logic [CfgDataW-1:0] pat_lo_q, pat_hi_q, msk_lo_q, msk_hi_q;
  logic [LenRegW-1:0]  len_q;

  // scan state
  logic [ByteW-1:0]      window_q [SigBytes];
  logic [OffsetBits-1:0] count_q;
  logic                  done_q;

  scan_res_t   match_reports_q [$];
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  function automatic int unsigned active_len();
    int unsigned n;
    n = len_q;
    if (n < 1) n = 1;
    if (n > PatternMax) n = PatternMax;
    return n;
  endfunction

  function automatic bit window_hit(input int unsigned n);
    logic [ByteW-1:0] pat, msk, got;
    for (int unsigned i = 0; i < n; i++) begin
      pat = (i < 8) ? pat_lo_q[(i % 8) * 8 +: 8] : pat_hi_q[(i % 8) * 8 +: 8];
      msk = (i < 8) ? msk_lo_q[(i % 8) * 8 +: 8] : msk_hi_q[(i % 8) * 8 +: 8];
      got = window_q[(n - 1 - i) % SigBytes];
      if ((got & msk) != (pat & msk)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_scan();
    for (int i = 0; i < SigBytes; i++) window_q[i] = '0;
    count_q = '0;
    done_q  = 1'b0;
  endfunction

  // Advance the scan by one byte; returns 1 when the byte yields a report.
  function automatic bit scan_byte(input logic [ByteW-1:0] d, input logic l,
                                   output scan_res_t r);
    int unsigned n;
    bit          has_res;
    n       = active_len();
    has_res = 1'b0;
    r       = '0;
    for (int k = SigBytes - 1; k > 0; k--) window_q[k] = window_q[k - 1];
    window_q[0] = d;
    if (count_q != '1) count_q = count_q + 1'b1;
    if (!done_q && count_q >= n && window_hit(n)) begin
      done_q         = 1'b1;
      r.found        = 1'b1;
      r.match_offset = OffsetOutW'(count_q - n);
      has_res        = 1'b1;
    end
    if (l) begin
      // no match in this buffer: not-found report on its last byte
      if (!done_q) has_res = 1'b1;
      clear_scan();
    end
    return has_res;
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_res_t want, got;
    if (!rst_ni) begin
      pat_lo_q = '0;
      pat_hi_q = '0;
      msk_lo_q = '0;
      msk_hi_q = '0;
      len_q    = LenRegW'(1);
      clear_scan();
      match_reports_q.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBytesLow:  pat_lo_q = cfg_wdata_i;
          CfgBytesHigh: pat_hi_q = cfg_wdata_i;
          CfgMasksLow:  msk_lo_q = cfg_wdata_i;
          CfgMasksHigh: msk_hi_q = cfg_wdata_i;
          CfgLength:    len_q    = cfg_wdata_i[LenRegW-1:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        got.found        = res_mon.found;
        got.match_offset = res_mon.match_offset;
        if (match_reports_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result found=%0d offset=%0d",
                                  got.found, got.match_offset));
        end else begin
          want = match_reports_q.pop_front();
          if (got.found !== want.found || got.match_offset !== want.match_offset)
            flag_mismatch($sformatf("expected found=%0d offset=%0d, got found=%0d offset=%0d",
                                    want.found, want.match_offset,
                                    got.found, got.match_offset));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (scan_byte(req_mon.data_byte, req_mon.last_byte, want))
          match_reports_q.push_back(want);
      end
      pending_o <= match_reports_q.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the masked byte pattern scan unit
// Programs signatures, streams buffers with embedded, broken and absent
// matches under random back pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import msps_pkg::*;

  localparam int unsigned TotalItems   = 1400;
  // spare cycles at the end of settle, before the next writes
  localparam int unsigned SettleCycles = 4;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  msps_req_if req_if ();
  msps_res_if res_if ();

  int unsigned pending;
  int unsigned fail_count;

  // idle probabilities in percent, per cycle
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned sent_cnt;

  // stimulus-side copy of the programmed signature, used to build matches
  logic [ByteW-1:0] sig_byte [SigBytes];
  logic [ByteW-1:0] sig_mask [SigBytes];
  int unsigned      sig_len;

  masked_byte_pattern_scan_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  msps_scan_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_mon      (req_if),
    .res_mon      (res_if),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: random stalls, rate set by the current idle phase.
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One register write, taken at the next edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Offer one byte request, with random gaps ahead of it; returns on acceptance.
  task automatic send_byte(input logic [ByteW-1:0] d, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.data_byte <= d;
    req_if.last_byte <= l;
    do @(posedge clk_i); while (!req_if.ready);
    sent_cnt++;
  endtask

  // n random bytes; the final one closes the buffer when end_buf is set.
  task automatic send_noise(input int unsigned n, input bit end_buf);
    for (int unsigned i = 0; i < n; i++) send_byte(ByteW'($urandom), end_buf && i == n - 1);
  endtask

  // Bytes that satisfy the signature; wildcard bits are random. With corrupt set,
  // one masked bit of one byte, if that byte has one, is flipped so that spot cannot match.
  task automatic send_signature(input bit corrupt, input bit end_buf);
    int unsigned      bad;
    logic [ByteW-1:0] b, flip;
    bad = $urandom_range(sig_len - 1);
    for (int unsigned i = 0; i < sig_len; i++) begin
      b = (sig_byte[i] & sig_mask[i]) | (ByteW'($urandom) & ~sig_mask[i]);
      if (corrupt && i == bad) begin
        flip = sig_mask[i] & (ByteW'(1) << $urandom_range(ByteW - 1));
        if (flip == '0) flip = sig_mask[i];
        b ^= flip;
      end
      send_byte(b, end_buf && i == sig_len - 1);
    end
  endtask

  // Drop valid and wait until every predicted report has been taken,
  // then wait out a byte still in flight that reports nothing.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all signature registers from the local copy.
  task automatic load_signature(input logic [LenRegW-1:0] len_raw);
    logic [CfgDataW-1:0] w_pb_lo, w_pb_hi, w_pm_lo, w_pm_hi;
    for (int i = 0; i < 8; i++) begin
      w_pb_lo[i*8 +: 8] = sig_byte[i];
      w_pb_hi[i*8 +: 8] = sig_byte[i+8];
      w_pm_lo[i*8 +: 8] = sig_mask[i];
      w_pm_hi[i*8 +: 8] = sig_mask[i+8];
    end
    write_reg(CfgBytesLow,  w_pb_lo);
    write_reg(CfgBytesHigh, w_pb_hi);
    write_reg(CfgMasksLow,  w_pm_lo);
    write_reg(CfgMasksHigh, w_pm_hi);
    write_reg(CfgLength,    CfgDataW'(len_raw));
    // length 0 acts as 1, anything above the maximum as the maximum
    sig_len = (len_raw == 0) ? 1 : (len_raw > SigBytes) ? SigBytes : len_raw;
  endtask

  // Random signature: extreme or random bytes, mostly exact masks with some
  // wildcards, lengths weighted toward the edges of the range.
  task automatic pick_signature();
    int unsigned        style, r;
    logic [LenRegW-1:0] len_raw;
    style = $urandom_range(7);
    for (int i = 0; i < SigBytes; i++) begin
      sig_byte[i] = (style == 0) ? '0 : (style == 1) ? '1 : ByteW'($urandom);
      r = $urandom_range(19);
      sig_mask[i] = (r < 14) ? '1 : (r < 17) ? '0 : ByteW'($urandom);
      if (style == 2) sig_mask[i] = '1;
      if (style == 3) sig_mask[i] = '0;   // all wildcard
    end
    r = $urandom_range(11);
    case (r)
      0:       len_raw = '0;
      1:       len_raw = LenRegW'(SigBytes);
      2:       len_raw = LenRegW'($urandom_range(2**LenRegW - 1, SigBytes + 1));
      3:       len_raw = LenRegW'(1);
      default: len_raw = LenRegW'($urandom_range(SigBytes, 1));
    endcase
    load_signature(len_raw);
    // a write to an index past the register list must change nothing
    if ($urandom_range(3) == 0)
      write_reg(CfgIdxW'($urandom_range(2**CfgIdxW - 1, int'(CfgLength) + 1)),
                {$urandom, $urandom});
  endtask

  // One buffer: mostly well-formed with a match somewhere, else a broken
  // signature, pure noise (often shorter than the signature) or two matches.
  task automatic send_random_buffer();
    int unsigned kind, prefix, suffix;
    kind   = $urandom_range(9);
    prefix = $urandom_range(10);
    suffix = $urandom_range(6);
    if (kind <= 5) begin
      send_noise(prefix, 1'b0);
      send_signature(1'b0, suffix == 0);
      send_noise(suffix, 1'b1);
    end else if (kind <= 7) begin
      send_noise(prefix, 1'b0);
      send_signature(1'b1, suffix == 0);
      send_noise(suffix, 1'b1);
    end else if (kind == 8) begin
      send_noise($urandom_range(24, 1), 1'b1);
    end else begin
      // second match must be ignored
      send_noise(prefix, 1'b0);
      send_signature(1'b0, 1'b0);
      send_signature(1'b0, 1'b1);
    end
  endtask

  initial begin
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_wdata_i      = '0;
    req_if.valid     = 1'b0;
    req_if.data_byte = '0;
    req_if.last_byte = 1'b0;
    res_if.ready     = 1'b0;
    send_idle_pct    = 38;
    recv_idle_pct    = 86;
    sent_cnt         = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // Reset setting: length 1, zero mask, so the first byte always matches.
    send_byte(8'h00, 1'b1);           // match on the last byte
    send_byte(8'hFF, 1'b0);           // match before the last byte
    send_byte(8'h5A, 1'b1);           // last byte then reports nothing
    settle();

    for (int i = 0; i < SigBytes; i++) begin
      sig_byte[i] = ByteW'(i * 17);
      sig_mask[i] = '1;
    end
    sig_byte[0] = 8'h00;
    sig_byte[1] = 8'hFF;
    sig_byte[2] = 8'h3C;
    sig_byte[3] = 8'hC3;
    load_signature(LenRegW'(4));
    write_reg(CfgIdxW'(int'(CfgLength) + 1), '1);   // index past the list
    send_byte(8'h00, 1'b0);           // buffer shorter than the signature
    send_byte(8'hFF, 1'b1);
    send_byte(8'h11, 1'b0);           // match at offset 1, on the last byte
    send_signature(1'b0, 1'b1);
    send_signature(1'b0, 1'b0);       // match, then one trailing byte
    send_noise(1, 1'b1);
    settle();

    // length 0 acts as 1; upper nibble compared only
    sig_byte[0] = 8'hA5;
    sig_mask[0] = 8'hF0;
    load_signature('0);
    send_byte(8'hAF, 1'b1);           // masked match
    send_byte(8'h5F, 1'b1);           // not found
    settle();

    // --- random phases ---
    while (sent_cnt < TotalItems) begin
      if (sent_cnt < TotalItems / 3) begin
        send_idle_pct <= 38;
        recv_idle_pct <= 86;
      end else if (sent_cnt < 2 * TotalItems / 3) begin
        send_idle_pct <= 86;
        recv_idle_pct <= 38;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      pick_signature();
      repeat ($urandom_range(12, 4)) send_random_buffer();
      settle();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(400_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

### masked_byte_pattern_scan_unit.f
src/msps_pkg.sv
src/msps_if.sv
src/msps_cfg_regs.sv
src/msps_match.sv
src/masked_byte_pattern_scan_unit.sv
src/msps_checker.sv
bench/msps_scan_checker.sv
bench/tb.sv
